// ----- rtl/pfba_pkg.sv -----
package pfba_pkg;

  // Bitmap geometry: one byte holds eight page frames.
  localparam int BITMAP_BYTES = 131072;
  localparam int ADDR_W       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int HINT_W       = 17;
  localparam int FRAME_W      = 20;
  localparam int BIT_W        = 3;
  localparam int BYTE_W       = 8;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BITMAP_BYTES - 1);
  localparam logic [HINT_W:0]   BYTES_EXT = (HINT_W + 1)'(BITMAP_BYTES);

  // Request codes carried in the input tuser.
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_MARK  = 2'd2
  } req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_POST
  } state_t;

  // Result of the shared byte unit.
  typedef struct packed {
    logic              full;
    logic [BIT_W-1:0]  low_clear;
    logic [BYTE_W-1:0] byte_out;
  } bu_res_t;

  // Bitmap memory access from the sequencer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/pfba_ram.sv -----
module pfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pfba_byte_unit.sv -----
module pfba_byte_unit (
  input  pfba_pkg::req_t                  op,
  input  logic [pfba_pkg::BYTE_W-1:0]     byte_in,
  input  logic [pfba_pkg::BIT_W-1:0]      bit_sel,
  output pfba_pkg::bu_res_t               res
);

  logic [pfba_pkg::BIT_W-1:0]  low;
  logic                        found;
  logic [pfba_pkg::BYTE_W-1:0] sel_mask;
  logic [pfba_pkg::BYTE_W-1:0] low_mask;

  // Priority search for the lowest clear bit of the byte.
  always_comb begin
    low   = '0;
    found = 1'b0;
    for (int i = 0; i < pfba_pkg::BYTE_W; i++) begin
      if (!found && !byte_in[i]) begin
        low   = pfba_pkg::BIT_W'(i);
        found = 1'b1;
      end
    end
  end

  assign sel_mask = pfba_pkg::BYTE_W'(1) << bit_sel;
  assign low_mask = pfba_pkg::BYTE_W'(1) << low;

  // New byte value for each kind of request.
  always_comb begin
    res.full      = ~found;
    res.low_clear = low;
    case (op)
      pfba_pkg::REQ_ALLOC: res.byte_out = byte_in | low_mask;
      pfba_pkg::REQ_FREE:  res.byte_out = byte_in & ~sel_mask;
      pfba_pkg::REQ_MARK:  res.byte_out = byte_in | sel_mask;
      default:             res.byte_out = byte_in;
    endcase
  end

endmodule

// ----- rtl/pfba_ctrl.sv -----
module pfba_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [1:0]                       in_tuser,
  input  logic [pfba_pkg::FRAME_W-1:0]     in_frame,
  input  logic                             cfg_valid,
  input  logic [pfba_pkg::HINT_W-1:0]      cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pfba_pkg::FRAME_W-1:0]     out_frame,
  output logic                             out_fail,
  output pfba_pkg::mem_req_t               mem_req,
  input  logic [pfba_pkg::BYTE_W-1:0]      mem_rdata
);

  pfba_pkg::state_t                state_r, state_nxt;
  logic [pfba_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  pfba_pkg::req_t                  op_r, op_nxt;
  logic [pfba_pkg::BIT_W-1:0]      bit_r, bit_nxt;
  logic [pfba_pkg::HINT_W-1:0]     hint_r, hint_nxt;
  logic [pfba_pkg::FRAME_W-1:0]    res_frame_r, res_frame_nxt;
  logic                            res_fail_r, res_fail_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [pfba_pkg::FRAME_W-1:0]    out_frame_r, out_frame_nxt;
  logic                            out_fail_r, out_fail_nxt;

  pfba_pkg::req_t                  in_op;
  logic [pfba_pkg::HINT_W-1:0]     in_byte;
  logic                            hint_ok;
  logic                            byte_ok;
  logic                            accept;
  logic                            out_free;
  logic                            at_last;
  logic                            scan_on;
  pfba_pkg::bu_res_t               bu;

  assign in_op    = pfba_pkg::req_t'(in_tuser);
  assign in_byte  = in_frame[pfba_pkg::BIT_W +: pfba_pkg::HINT_W];
  assign hint_ok  = {1'b0, hint_r} < pfba_pkg::BYTES_EXT;
  assign byte_ok  = {1'b0, in_byte} < pfba_pkg::BYTES_EXT;
  assign in_tready = (state_r == pfba_pkg::ST_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign at_last  = (addr_r == pfba_pkg::LAST_ADDR);
  // A scan goes on while the byte just read is full and bytes remain.
  assign scan_on  = (op_r == pfba_pkg::REQ_ALLOC) && bu.full && !at_last;

  // Shared byte unit: lowest clear bit and the updated byte.
  pfba_byte_unit u_byte_unit (
    .op      (op_r),
    .byte_in (mem_rdata),
    .bit_sel (bit_r),
    .res     (bu)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfba_pkg::ST_CLEAR: begin
        if (at_last) state_nxt = pfba_pkg::ST_IDLE;
      end
      pfba_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op)
            pfba_pkg::REQ_ALLOC: state_nxt = hint_ok ? pfba_pkg::ST_READ : pfba_pkg::ST_POST;
            pfba_pkg::REQ_FREE,
            pfba_pkg::REQ_MARK:  state_nxt = byte_ok ? pfba_pkg::ST_READ : pfba_pkg::ST_POST;
            default:             state_nxt = pfba_pkg::ST_POST;
          endcase
        end
      end
      pfba_pkg::ST_READ:  state_nxt = pfba_pkg::ST_CHECK;
      pfba_pkg::ST_CHECK: state_nxt = scan_on ? pfba_pkg::ST_READ : pfba_pkg::ST_POST;
      pfba_pkg::ST_POST: begin
        if (out_free) state_nxt = pfba_pkg::ST_IDLE;
      end
      default: state_nxt = pfba_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    addr_nxt      = addr_r;
    op_nxt        = op_r;
    bit_nxt       = bit_r;
    hint_nxt      = hint_r;
    res_frame_nxt = res_frame_r;
    res_fail_nxt  = res_fail_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = addr_r;
    mem_req.wdata = bu.byte_out;
    mem_req.raddr = addr_r;

    case (state_r)
      pfba_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = '0;
        addr_nxt      = addr_r + 1'b1;
      end
      pfba_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt        = in_op;
          bit_nxt       = in_frame[pfba_pkg::BIT_W-1:0];
          res_frame_nxt = '0;
          res_fail_nxt  = (in_op == pfba_pkg::REQ_ALLOC);
          if (in_op == pfba_pkg::REQ_ALLOC) begin
            addr_nxt = hint_r[pfba_pkg::ADDR_W-1:0];
          end else begin
            addr_nxt = in_byte[pfba_pkg::ADDR_W-1:0];
          end
        end
      end
      pfba_pkg::ST_CHECK: begin
        if (op_r == pfba_pkg::REQ_ALLOC) begin
          if (!bu.full) begin
            // Clear bit found: take it and move the hint here.
            mem_req.we    = 1'b1;
            hint_nxt      = pfba_pkg::HINT_W'(addr_r);
            res_frame_nxt = pfba_pkg::FRAME_W'({pfba_pkg::HINT_W'(addr_r), bu.low_clear});
            res_fail_nxt  = 1'b0;
          end else if (!at_last) begin
            addr_nxt = addr_r + 1'b1;
          end else begin
            res_frame_nxt = '0;
            res_fail_nxt  = 1'b1;
          end
        end else begin
          mem_req.we    = 1'b1;
          res_frame_nxt = '0;
          res_fail_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // Configuration reloads the hint; the user must write it only while idle, the block itself does not enforce this.
    if (cfg_valid) begin
      hint_nxt = cfg_data;
    end
  end

  // Output register: a finished request waits here for the consumer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_frame_nxt = out_frame_r;
    out_fail_nxt  = out_fail_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == pfba_pkg::ST_POST && out_free) begin
      out_valid_nxt = 1'b1;
      out_frame_nxt = res_frame_r;
      out_fail_nxt  = res_fail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfba_pkg::ST_CLEAR;
      addr_r      <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    bit_r       <= bit_nxt;
    res_frame_r <= res_frame_nxt;
    res_fail_r  <= res_fail_nxt;
    out_frame_r <= out_frame_nxt;
    out_fail_r  <= out_fail_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_frame  = out_frame_r;
  assign out_fail   = out_fail_r;

endmodule

// ----- rtl/page_frame_bitmap_allocator.sv -----
// Channel   Direction  Handshake            Payload
// in_       request    in_tvalid/in_tready   tuser: req_type; tdata: frame_number
// out_      result     out_tvalid/out_tready tdata: alloc_frame; tuser: status
// cfg_      register   cfg_valid/cfg_ready   cfg_data: start_byte (reloads the hint)
//
// Each request is accepted in the idle state; each bitmap byte is then read,
// then checked and written back, and the result is posted last. A free, a mark
// or an allocate that hits at the hint reads one byte; a scan reads bytes up
// from the hint until one has a clear bit or the last byte has been checked.
// After reset a clearing pass zeroes every bitmap byte before the
// first request is taken. A stalled result waits in the output register.
module page_frame_bitmap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] frame_number, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [19:0] alloc_frame, [23:20] zero
  output logic        out_tuser,  // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data    // [16:0] start_byte
);

  pfba_pkg::mem_req_t               mem_req;
  logic [pfba_pkg::BYTE_W-1:0]      mem_rdata;
  logic [pfba_pkg::FRAME_W-1:0]     out_frame;

  assign cfg_ready = 1'b1;

  // Request sequencer with the shared byte unit.
  pfba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_frame   (in_tdata[pfba_pkg::FRAME_W-1:0]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_frame  (out_frame),
    .out_fail   (out_tuser),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  // Frame bitmap storage.
  pfba_ram #(
    .WIDTH (pfba_pkg::BYTE_W),
    .DEPTH (pfba_pkg::BITMAP_BYTES)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = {4'b0000, out_frame};

endmodule

// ----- dv/pfba_grant_checker.sv -----
module pfba_grant_checker
  import pfba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] frame_number, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [19:0] alloc_frame, [23:20] zero
  input  logic        out_tuser,  // [0] status
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_data,   // [16:0] start_byte
  output int          mismatches,
  output int          open_reqs
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result: the granted frame and the failure flag.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               status;
  } grant_t;

  // Shadow copy of the frame bitmap and the next-fit hint.
  bit   [BYTE_W-1:0] frame_map [BITMAP_BYTES];
  logic [HINT_W-1:0] scan_hint;
  grant_t            pending_grants [$];
  int                errors;

  assign mismatches = errors;

  initial begin
    errors    = 0;
    open_reqs = 0;
    scan_hint = '0;
  end

  // Applies one request to the shadow state and returns the result it causes.
  function automatic grant_t serve_request(logic [1:0] kind, logic [FRAME_W-1:0] frame);
    grant_t      g;
    int unsigned idx;
    int unsigned byte_idx;
    int          b;
    bit          found;
    g        = '0;
    found    = 1'b0;
    byte_idx = frame >> 3;
    case (kind)
      REQ_ALLOC: begin
        // Next-fit scan: first byte at or after the hint with a clear bit.
        for (idx = scan_hint; idx < BITMAP_BYTES && !found; idx++) begin
          if (frame_map[idx] != 8'hFF) begin
            b = 0;
            while (frame_map[idx][b]) b++;
            frame_map[idx][b] = 1'b1;
            scan_hint = HINT_W'(idx);
            g.frame   = FRAME_W'(idx * 8 + b);
            found     = 1'b1;
          end
        end
        g.status = !found;
      end
      REQ_FREE: begin
        if (byte_idx < BITMAP_BYTES) frame_map[byte_idx][frame[2:0]] = 1'b0;
      end
      REQ_MARK: begin
        if (byte_idx < BITMAP_BYTES) frame_map[byte_idx][frame[2:0]] = 1'b1;
      end
      default: ;
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst_n) begin
      foreach (frame_map[i]) frame_map[i] = '0;
      scan_hint = '0;
      pending_grants.delete();
    end else begin
      // A register write reloads the hint.
      if (cfg_valid && cfg_ready) scan_hint = cfg_data;

      // Compare each result with the oldest outstanding request.
      if (out_tvalid && out_tready) begin
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected result frame %0d status %0d, none expected",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          exp_g = pending_grants.pop_front();
          if (out_tdata !== {4'b0, exp_g.frame} || out_tuser !== exp_g.status) begin
            $display("%0t: result mismatch: expected frame %0d status %0d, got frame %0d status %0d",
                     $time, exp_g.frame, exp_g.status, out_tdata, out_tuser);
            errors++;
          end
        end
      end

      // Each accepted request yields exactly one result.
      if (in_tvalid && in_tready)
        pending_grants.push_back(serve_request(in_tuser, in_tdata[FRAME_W-1:0]));
    end
    open_reqs <= pending_grants.size();
  end

endmodule

// ----- dv/tb_page_frame_bitmap_allocator.sv -----
module tb_page_frame_bitmap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import pfba_pkg::*;

  // Code that the block must accept and answer without any effect.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [FRAME_W-1:0] TOP_FRAME = '1;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data   = '0;
  int          mismatches;
  int          open_reqs;

  // Byte the stimulus aims at, and frames recently granted, for frees.
  logic [HINT_W-1:0]  focus_byte = '0;
  logic [FRAME_W-1:0] granted [$];
  bit                 steady;

  always #5 clk = ~clk;

  page_frame_bitmap_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  pfba_grant_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .open_reqs  (open_reqs)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Frames near the hint keep scans short; some are granted ones or anywhere.
  function automatic logic [FRAME_W-1:0] pick_frame();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 35 && granted.size() > 0) begin
      k = $urandom_range(0, granted.size() - 1);
      pick_frame = granted[k];
      granted.delete(k);
    end else if (r < 93) begin
      pick_frame = FRAME_W'({focus_byte, 3'b000} + $urandom_range(0, 127));
    end else begin
      pick_frame = FRAME_W'($urandom);
    end
  endfunction

  // Track grants seen on the result side to steer later requests.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && !out_tuser && out_tdata[FRAME_W-1:0] != '0) begin
      granted.push_back(out_tdata[FRAME_W-1:0]);
      if (granted.size() > 256) void'(granted.pop_front());
      if (out_tdata[FRAME_W-1:3] > focus_byte) focus_byte = out_tdata[FRAME_W-1:3];
    end
  end

  // Result side back-pressure, with occasional long stretches of no stall.
  initial begin
    int hold;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      out_tready <= 1'b1;
      repeat (hold) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Issue one request and wait for it to be taken; valid stays high afterwards.
  task automatic send_request(logic [1:0] kind, logic [FRAME_W-1:0] frame);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, frame};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_reqs != 0);
  endtask

  // Register write; no request is outstanding whenever this is called.
  task automatic write_start(logic [HINT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    focus_byte = value;
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      send_request(REQ_ALLOC, FRAME_W'($urandom));
    else if (r < 72) send_request(REQ_FREE, pick_frame());
    else if (r < 95) send_request(REQ_MARK, pick_frame());
    else             send_request(REQ_UNUSED, FRAME_W'($urandom));
  endtask

  initial begin
    int n;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: low end of the bitmap, frees and marks, the unused code.
    write_start('0);
    repeat (3) send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, 20'd1);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_MARK, TOP_FRAME);
    send_request(REQ_FREE, TOP_FRAME);
    send_request(REQ_UNUSED, TOP_FRAME);
    for (int f = 3; f < 8; f++) send_request(REQ_MARK, FRAME_W'(f));
    // Byte zero is now full, so this request moves on to the next byte.
    send_request(REQ_ALLOC, TOP_FRAME);
    drain();

    // Directed: hint at the last byte, fill it and run past the end of the bitmap.
    write_start(LAST_ADDR);
    repeat (9) send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, TOP_FRAME - 20'd5);
    repeat (2) send_request(REQ_ALLOC, '0);
    drain();

    // Random phases, each with a fresh start byte written while idle.
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0:       write_start(HINT_W'($urandom_range(0, BITMAP_BYTES - 1)));
        1:       write_start(HINT_W'($urandom_range(BITMAP_BYTES - 64, BITMAP_BYTES - 1)));
        2:       write_start(HINT_W'($urandom_range(0, 255)));
        default: write_start($urandom_range(0, 1) ? LAST_ADDR : '0);
      endcase
      steady = ($urandom_range(0, 2) == 0);
      n = $urandom_range(180, 240);
      repeat (n) random_request();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && open_reqs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: covers the clearing pass and the slowest legal run many times over.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
